// ===== hw/rtl/hdmi_line_slot_scheduler_assert.svh =====
// Assertion macros for the HDMI line slot scheduler.
// Needs no other file; the macros compile to nothing when SYNTHESIS is set.
`ifndef HDMI_LINE_SLOT_SCHEDULER_ASSERT_SVH
`define HDMI_LINE_SLOT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define HLS_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define HLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define HLS_ASSERT(label, clk, rst_n, expr)

`define HLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/hls_pkg.sv =====
// Shared types and constants of the HDMI line slot scheduler.
// Has no dependencies; the interfaces, the config register file and the scheduler use it.
package hls_pkg;

  localparam int unsigned LINE_W   = 10;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned CREDIT_W = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_V_FRONT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_V_SYNC       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_V_BACK       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_V_ACTIVE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CREDIT_LINE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CREDIT_PKT   = 3'd5;

  localparam logic [LINE_W-1:0]   V_FRONT_RST     = 10'd10;
  localparam logic [LINE_W-1:0]   V_SYNC_RST      = 10'd2;
  localparam logic [LINE_W-1:0]   V_BACK_RST      = 10'd33;
  localparam logic [LINE_W-1:0]   V_ACTIVE_RST    = 10'd480;
  localparam logic [CREDIT_W-1:0] CREDIT_LINE_RST = 32'd99864;
  localparam logic [CREDIT_W-1:0] CREDIT_PKT_RST  = 32'd262144;
  localparam logic [COUNT_W-1:0]  LINE_COUNT_RST  = 12'd2;

  typedef enum logic [2:0] {
    KIND_BLANK        = 3'd0,
    KIND_BLANK_AVI    = 3'd1,
    KIND_VSYNC_ACR    = 3'd2,
    KIND_VSYNC_AINFO  = 3'd3,
    KIND_BLANK_AUDIO  = 3'd4,
    KIND_ACTIVE_CMD   = 3'd5,
    KIND_ACTIVE_AUDIO = 3'd6,
    KIND_PIXEL_ROW    = 3'd7
  } slot_kind_e;

  typedef struct packed {
    logic [LINE_W-1:0]   v_front_lines;
    logic [LINE_W-1:0]   v_sync_lines;
    logic [LINE_W-1:0]   v_back_lines;
    logic [LINE_W-1:0]   v_active_lines;
    logic [CREDIT_W-1:0] credit_per_line;
    logic [CREDIT_W-1:0] credit_per_packet;
  } cfg_t;

endpackage

// ===== hw/rtl/hls_if.sv =====
// Channel interfaces of the HDMI line slot scheduler: request, result, config write.
// Depends on hls_pkg for field widths.
interface hls_req_if;
  logic valid;
  logic ready;
  logic packet_ready;
  modport source (output valid, output packet_ready, input ready);
  modport sink (input valid, input packet_ready, output ready);
endinterface

interface hls_res_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  slot_kind;
  logic [hls_pkg::LINE_W-1:0]  pixel_row;
  logic                        buffer_pick;
  logic                        packet_taken;
  logic                        frame_begin;
  modport source (output valid, output slot_kind, output pixel_row, output buffer_pick,
                  output packet_taken, output frame_begin, input ready);
  modport sink (input valid, input slot_kind, input pixel_row, input buffer_pick,
                input packet_taken, input frame_begin, output ready);
endinterface

interface hls_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hls_pkg::REG_IDX_W-1:0] wr_index;
  logic [hls_pkg::CREDIT_W-1:0]  wr_data;
  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== hw/rtl/hls_cfg_regs.sv =====
// Configuration register file of the HDMI line slot scheduler.
// Depends on hls_pkg and the hls_cfg_if interface.
module hls_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  hls_cfg_if.sink       cfg_i,
  output hls_pkg::cfg_t cfg_o
);
  import hls_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.wr_index)
        REG_V_FRONT:     cfg_d.v_front_lines     = cfg_i.wr_data[LINE_W-1:0];
        REG_V_SYNC:      cfg_d.v_sync_lines      = cfg_i.wr_data[LINE_W-1:0];
        REG_V_BACK:      cfg_d.v_back_lines      = cfg_i.wr_data[LINE_W-1:0];
        REG_V_ACTIVE:    cfg_d.v_active_lines    = cfg_i.wr_data[LINE_W-1:0];
        REG_CREDIT_LINE: cfg_d.credit_per_line   = cfg_i.wr_data;
        REG_CREDIT_PKT:  cfg_d.credit_per_packet = cfg_i.wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.v_front_lines     <= V_FRONT_RST;
      cfg_q.v_sync_lines      <= V_SYNC_RST;
      cfg_q.v_back_lines      <= V_BACK_RST;
      cfg_q.v_active_lines    <= V_ACTIVE_RST;
      cfg_q.credit_per_line   <= CREDIT_LINE_RST;
      cfg_q.credit_per_packet <= CREDIT_PKT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/hdmi_line_slot_scheduler.sv =====
// HDMI line slot scheduler: one result beat for every request beat.
// A valid result follows in the cycle after request acceptance; throughput is one beat per
// cycle unless an untaken result stalls requests; line counter and credit update per beat.
// The result register frees in the cycle it is taken, so requests flow while results drain.
// Reset loads the register defaults, sets the line counter to two and clears the credit,
// the ping/pong toggle, the pending row half and the result valid.
`include "hdmi_line_slot_scheduler_assert.svh"

module hdmi_line_slot_scheduler (
  input logic       clk_i,
  input logic       rst_ni,
  hls_req_if.sink   req_i,
  hls_res_if.source res_o,
  hls_cfg_if.sink   cfg_i
);
  import hls_pkg::*;

  cfg_t cfg;

  hls_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic [COUNT_W-1:0]  line_q, line_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic                pong_q, pong_d;
  logic                pend_q, pend_d;

  logic                out_valid_q;
  slot_kind_e          kind_q, kind_d;
  logic [LINE_W-1:0]   row_q, row_d;
  logic                taken_q, taken_d;
  logic                fbegin_q, fbegin_d;

  logic                accept;
  logic [COUNT_W-1:0]  bound_fs, bound_fsb, bound_total;
  logic [COUNT_W-1:0]  f_ext;
  logic                in_vsync, in_active;
  logic [CREDIT_W-1:0] credit_add;
  logic                can_take;
  logic [COUNT_W:0]    line_next;
  logic [COUNT_W-1:0]  row_full;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign f_ext       = {{(COUNT_W-LINE_W){1'b0}}, cfg.v_front_lines};
  assign bound_fs    = f_ext + {{(COUNT_W-LINE_W){1'b0}}, cfg.v_sync_lines};
  assign bound_fsb   = bound_fs + {{(COUNT_W-LINE_W){1'b0}}, cfg.v_back_lines};
  assign bound_total = bound_fsb + {{(COUNT_W-LINE_W){1'b0}}, cfg.v_active_lines};

  assign in_vsync    = (line_q >= f_ext) && (line_q < bound_fs);
  assign in_active   = !in_vsync && (line_q >= bound_fsb);
  assign credit_add  = credit_q + cfg.credit_per_line;
  assign can_take    = (credit_add >= cfg.credit_per_packet) && req_i.packet_ready;
  assign line_next   = {1'b0, line_q} + {{COUNT_W{1'b0}}, 1'b1};
  assign row_full    = line_q - bound_fsb;

  always_comb begin
    credit_d = credit_add;
    pend_d   = 1'b0;
    kind_d   = KIND_BLANK;
    row_d    = '0;
    taken_d  = 1'b0;
    fbegin_d = 1'b0;
    pong_d   = ~pong_q;
    if (in_vsync) begin
      if (line_q == f_ext) begin
        kind_d   = KIND_VSYNC_ACR;
        fbegin_d = 1'b1;
      end else begin
        kind_d = KIND_VSYNC_AINFO;
      end
    end else if (in_active) begin
      if (!pend_q) begin
        pend_d = 1'b1;
        if (can_take) begin
          credit_d = credit_add - cfg.credit_per_packet;
          kind_d   = KIND_ACTIVE_AUDIO;
          taken_d  = 1'b1;
        end else begin
          kind_d = KIND_ACTIVE_CMD;
        end
      end else begin
        credit_d = credit_q;
        kind_d   = KIND_PIXEL_ROW;
        row_d    = row_full[LINE_W-1:0];
      end
    end else begin
      if (line_q == '0) begin
        kind_d = KIND_BLANK_AVI;
      end else if (can_take) begin
        credit_d = credit_add - cfg.credit_per_packet;
        kind_d   = KIND_BLANK_AUDIO;
        taken_d  = 1'b1;
      end
    end

    line_d = line_q;
    if (!pend_d) begin
      line_d = (line_next >= {1'b0, bound_total}) ? '0 : line_next[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= LINE_COUNT_RST;
      credit_q    <= '0;
      pong_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        line_q      <= line_d;
        credit_q    <= credit_d;
        pong_q      <= pong_d;
        pend_q      <= pend_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_d;
      row_q    <= row_d;
      taken_q  <= taken_d;
      fbegin_q <= fbegin_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.slot_kind    = kind_q;
  assign res_o.pixel_row    = row_q;
  assign res_o.buffer_pick  = pong_q;
  assign res_o.packet_taken = taken_q;
  assign res_o.frame_begin  = fbegin_q;

  `HLS_ASSERT_NEXT(a_pend_sets_on_cmd, clk_i, rst_ni, accept && !pend_q,
    !pend_q || (kind_q == KIND_ACTIVE_CMD) || (kind_q == KIND_ACTIVE_AUDIO))
  `HLS_ASSERT(a_taken_kind, clk_i, rst_ni, !(out_valid_q && taken_q) ||
    (kind_q == KIND_BLANK_AUDIO) || (kind_q == KIND_ACTIVE_AUDIO))
  `HLS_ASSERT_NEXT(a_pong_flips, clk_i, rst_ni, accept, pong_q != $past(pong_q))
  `HLS_ASSERT(a_frame_begin_kind, clk_i, rst_ni, !(out_valid_q && fbegin_q) ||
    ((kind_q == KIND_VSYNC_ACR) && (row_q == '0)))

endmodule
